// File: hw/rtl/stt_pkg.sv
package stt_pkg;

   // Request kinds carried on req_tuser
   localparam logic REQ_SET  = 1'b0;
   localparam logic REQ_TAKE = 1'b1;

   // Fixed field widths of the stream words
   localparam int SEL_W      = 6;
   localparam int BIAS_W     = 6;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 8;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SET_LEAF,
      ST_SET_UP,
      ST_TAKE_ROOT,
      ST_TAKE_DOWN,
      ST_DONE
   } state_type;

endpackage

// File: hw/rtl/signal_tree_set_and_take_core.sv
// Signal tree core: a counting binary tree over 2^(LEVELS-1) one-bit signal flags.
// Requests arrive as words on the req_ channel: req_tuser selects set or take,
// req_tdata carries the leaf to set and the per-level bias bits. Every request
// produces exactly one word on the rsp_ channel: rsp_tuser is the success flag and
// rsp_tdata the index of the leaf cleared by a take (zero otherwise).
// All counts, and the leaf flags as nodes with a count of zero or one, live in one
// synchronous memory with two read ports and one write port, addressed in heap
// order. A set walks up from its leaf, a take walks down from the root, one tree
// level per cycle, so one memory read-modify-write step per level sets the pace.
// A successful request walks every level, then passes through the done state into the
// output register; a set of a leaf already set and a take from an empty tree end
// after the first memory read, a set beyond the leaves goes straight to the done state.
// Requests are handled one at a time: req_tready is high only while the core idles.
// After reset the core sweeps all 2^LEVELS-1 memory entries to zero, one entry a
// cycle, and holds req_tready low meanwhile.
// A finished result waits in the output register while the receiver stalls; the
// core goes on to accept and work on the next request, and holds that one's result
// internally until the output register is free.
module signal_tree_set_and_take_core
   import stt_pkg::*;
#(
   parameter int LEVELS = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [5:0] leaf_select, [11:6] bias_bits, rest zero
   input  logic                  req_tuser,  // [0] req_type
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // [5:0] leaf_found, rest zero
   output logic                  rsp_tuser   // [0] success
);

   localparam int NODE_W = LEVELS;                  // heap index of any node
   localparam int CNT_W  = LEVELS;                  // count of up to LEAVES leaves
   localparam int LEAVES = 1 << (LEVELS - 1);
   localparam int INNER  = LEAVES - 1;
   localparam int NODES  = 2 * LEAVES - 1;

   state_type state_ff, state_in;

   logic [NODE_W-1:0] node_ff, node_in;
   logic [NODE_W-1:0] clr_ff, clr_in;
   logic [BIAS_W-1:0] bias_ff, bias_in;
   logic              res_ok_ff, res_ok_in;
   logic [SEL_W-1:0]  res_leaf_ff, res_leaf_in;

   logic              rsp_valid_ff;
   logic              rsp_ok_ff;
   logic [SEL_W-1:0]  rsp_leaf_ff;

   logic              wr_en;
   logic [NODE_W-1:0] wr_addr;
   logic [CNT_W-1:0]  wr_data;
   logic [NODE_W-1:0] rd_a_addr;
   logic [NODE_W-1:0] rd_b_addr;
   logic [CNT_W-1:0]  rd_a_data;
   logic [CNT_W-1:0]  rd_b_data;

   logic [SEL_W-1:0]  in_sel;
   logic [BIAS_W-1:0] in_bias;
   logic              in_range;
   logic [NODE_W-1:0] in_leaf_node;
   logic              req_fire;
   logic              out_free;

   logic [NODE_W-1:0] parent;
   logic [NODE_W-1:0] left;
   logic [NODE_W-1:0] right;
   logic              pick_right;
   logic [NODE_W-1:0] pick;
   logic [CNT_W-1:0]  pick_cnt;
   logic              pick_is_leaf;
   logic [NODE_W-1:0] pick_left;
   logic [NODE_W-1:0] pick_right_child;

   stt_count_ram #(
      .ADDR_W (NODE_W),
      .DATA_W (CNT_W),
      .DEPTH  (NODES)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data)
   );

   assign in_sel       = req_tdata[SEL_W-1:0];
   assign in_bias      = req_tdata[SEL_W+BIAS_W-1:SEL_W];
   // Only relevant for small trees: a leaf index beyond the last leaf is ignored.
   assign in_range     = (32'(in_sel) < 32'(LEAVES));
   assign in_leaf_node = NODE_W'(32'(INNER) + 32'(in_sel));

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Tree navigation around the node held in node_ff.
   assign parent = NODE_W'((node_ff - NODE_W'(1)) >> 1);
   assign left   = NODE_W'({node_ff[NODE_W-2:0], 1'b1});
   assign right  = left + NODE_W'(1);

   // Take: choose the preferred child if its count is nonzero, the other otherwise.
   // The bias word is shifted one place per level, so levels without a bias bit
   // see a zero and prefer the left child.
   always_comb begin
      if (bias_ff[0]) begin
         pick_right = (rd_b_data != '0);
      end else begin
         pick_right = (rd_a_data == '0);
      end
   end
   assign pick             = pick_right ? right : left;
   assign pick_cnt         = pick_right ? rd_b_data : rd_a_data;
   assign pick_is_leaf     = (32'(pick) >= 32'(INNER));
   assign pick_left        = NODE_W'({pick[NODE_W-2:0], 1'b1});
   assign pick_right_child = pick_left + NODE_W'(1);

   always_comb begin
      state_in    = state_ff;
      node_in     = node_ff;
      clr_in      = clr_ff;
      bias_in     = bias_ff;
      res_ok_in   = res_ok_ff;
      res_leaf_in = res_leaf_ff;
      wr_en       = 1'b0;
      wr_addr     = node_ff;
      wr_data     = '0;
      rd_a_addr   = '0;
      rd_b_addr   = '0;

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + NODE_W'(1);
            if (32'(clr_ff) == 32'(NODES - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            res_ok_in   = 1'b0;
            res_leaf_in = '0;
            bias_in     = in_bias;
            if (req_tuser == REQ_SET) begin
               rd_a_addr = in_leaf_node;
               node_in   = in_leaf_node;
            end else begin
               rd_a_addr = '0;
               node_in   = '0;
            end
            if (req_fire) begin
               if (req_tuser == REQ_TAKE) begin
                  state_in = ST_TAKE_ROOT;
               end else if (in_range) begin
                  state_in = ST_SET_LEAF;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end

         ST_SET_LEAF: begin
            if (rd_a_data != '0) begin
               state_in = ST_DONE;
            end else begin
               wr_en     = 1'b1;
               wr_data   = CNT_W'(1);
               rd_a_addr = parent;
               node_in   = parent;
               state_in  = ST_SET_UP;
            end
         end

         ST_SET_UP: begin
            wr_en     = 1'b1;
            wr_data   = rd_a_data + CNT_W'(1);
            rd_a_addr = parent;
            node_in   = parent;
            if (node_ff == '0) begin
               res_ok_in = 1'b1;
               state_in  = ST_DONE;
            end
         end

         ST_TAKE_ROOT: begin
            if (rd_a_data == '0) begin
               state_in = ST_DONE;
            end else begin
               // Counts are decremented on the way down; a nonzero node always
               // has a nonzero child, so the descent ends on a set leaf.
               wr_en     = 1'b1;
               wr_data   = rd_a_data - CNT_W'(1);
               rd_a_addr = left;
               rd_b_addr = right;
               state_in  = ST_TAKE_DOWN;
            end
         end

         ST_TAKE_DOWN: begin
            rd_a_addr = pick_left;
            rd_b_addr = pick_right_child;
            node_in   = pick;
            bias_in   = bias_ff >> 1;
            if (pick_cnt == '0) begin
               state_in = ST_DONE;
            end else begin
               wr_en   = 1'b1;
               wr_addr = pick;
               wr_data = pick_cnt - CNT_W'(1);
               if (pick_is_leaf) begin
                  res_ok_in   = 1'b1;
                  res_leaf_in = SEL_W'(32'(pick) - 32'(INNER));
                  state_in    = ST_DONE;
               end
            end
         end

         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff     <= node_in;
      bias_ff     <= bias_in;
      res_ok_ff   <= res_ok_in;
      res_leaf_ff <= res_leaf_in;
   end

   // Output register: loaded from the held result when it is free or being drained.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_DONE && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && out_free) begin
         rsp_ok_ff   <= res_ok_ff;
         rsp_leaf_ff <= res_leaf_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ok_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - SEL_W){1'b0}}, rsp_leaf_ff};

endmodule

// File: hw/rtl/stt_count_ram.sv
module stt_count_ram
   import stt_pkg::*;
#(
   parameter int ADDR_W = 7,
   parameter int DATA_W = 7,
   parameter int DEPTH  = 127
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_a_addr,
   input  logic [ADDR_W-1:0] rd_b_addr,
   output logic [DATA_W-1:0] rd_a_data,
   output logic [DATA_W-1:0] rd_b_data
);

   // Two read ports and one write port, read data registered.
   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_a_data <= mem[rd_a_addr];
      rd_b_data <= mem[rd_b_addr];
   end

endmodule

// File: hw/rtl/stt_checker.sv
module stt_checker
   import stt_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser
);

   // A result held back by the receiver keeps its word.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // Requests are worked one at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while another is in work");

   // A failed request reports leaf zero.
   a_fail_leaf_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("failed result carries a leaf index");

   // No result can appear straight out of reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("channel active right after reset");

endmodule

bind signal_tree_set_and_take_core stt_checker u_stt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// File: sim/tb.sv
`timescale 1ns / 1ps

// Testbench for the signal tree core. Each request word is checked against a local
// model of the counting tree: leaf flags plus one count per inner node, updated the
// same way the core does, one request at a time. A short directed table comes first,
// then a long random run whose mix of sets and takes moves between filling and
// draining the tree, so that both full and empty trees are met many times.
module tb;
   import stt_pkg::*;

   localparam int TREE_LEVELS = 7;
   localparam int LEAF_COUNT  = 1 << (TREE_LEVELS - 1);
   localparam int INNER_COUNT = LEAF_COUNT - 1;
   localparam int BIAS_LEVELS = 6;      // levels that have a bias bit of their own
   localparam int RANDOM_WORDS = 1350;
   localparam int LONG_HOLD    = 300;   // receiver hold-off, in cycles
   localparam int CYCLE_LIMIT  = 400000;

   // One result word as the core should produce it.
   typedef struct packed {
      logic           success;
      logic [SEL_W-1:0] leaf_found;
   } tree_outcome_type;

   // A row of the directed table. Where typed is set, the outcome is written in by
   // hand and the model is only stepped along to keep its state in line.
   typedef struct packed {
      logic              kind;
      logic [SEL_W-1:0]  leaf_select;
      logic [BIAS_W-1:0] bias_bits;
      logic              typed;
      logic              success;
      logic [SEL_W-1:0]  leaf_found;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 23;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;  // [5:0] leaf_select, [11:6] bias_bits, rest zero
   logic                  req_tuser  = 1'b0; // [0] req_type
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // [5:0] leaf_found, rest zero
   logic                  rsp_tuser;        // [0] success

   // Local copy of the tree.
   bit          leaf_flags  [LEAF_COUNT];
   int unsigned node_counts [INNER_COUNT];

   tree_outcome_type outcomes_due[$];
   tree_outcome_type oldest_due;
   directed_row_type directed_rows [DIRECTED_ROWS];

   int  mismatch_count    = 0;
   int  cycle_count       = 0;
   int  stall_left        = 0;
   bit  quiet             = 1'b0;  // no idling on either side while set
   bit  long_hold_pending = 1'b0;

   signal_tree_set_and_take_core #(.LEVELS(TREE_LEVELS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   // Steps the local tree by one request and returns the word it should produce.
   // A set climbs from its leaf to the root raising every count; a take walks down
   // from the root, following the bias where the preferred side holds a set leaf.
   function automatic tree_outcome_type tree_outcome(logic kind,
                                                     logic [SEL_W-1:0] leaf_select,
                                                     logic [BIAS_W-1:0] bias_bits);
      tree_outcome_type result;
      int node;
      int level;
      int left;
      int right;
      int leaf;
      int unsigned left_count;
      int unsigned right_count;
      bit prefer_right;
      result = '0;
      if (kind == REQ_SET) begin
         // A leaf beyond the tree, or one already raised, leaves everything as it is.
         if (int'(leaf_select) >= LEAF_COUNT || leaf_flags[leaf_select])
            return result;
         leaf_flags[leaf_select] = 1'b1;
         node = int'(leaf_select) + INNER_COUNT;
         while (node != 0) begin
            node = (node - 1) >> 1;
            node_counts[node]++;
         end
         result.success = 1'b1;
         return result;
      end
      // Taking from an empty tree fails with a zero index.
      if (node_counts[0] == 0)
         return result;
      node  = 0;
      level = 0;
      while (node < INNER_COUNT) begin
         left  = 2 * node + 1;
         right = left + 1;
         if (left >= INNER_COUNT) begin
            left_count  = 32'(leaf_flags[left - INNER_COUNT]);
            right_count = 32'(leaf_flags[right - INNER_COUNT]);
         end else begin
            left_count  = node_counts[left];
            right_count = node_counts[right];
         end
         // Levels without a bias bit of their own lean to the left.
         prefer_right = (level < BIAS_LEVELS) && bias_bits[level];
         if (prefer_right)
            node = (right_count != 0) ? right : left;
         else
            node = (left_count != 0) ? left : right;
         level++;
      end
      leaf = node - INNER_COUNT;
      if (!leaf_flags[leaf])
         return result;
      leaf_flags[leaf] = 1'b0;
      while (node != 0) begin
         node = (node - 1) >> 1;
         if (node_counts[node] != 0)
            node_counts[node]--;
      end
      result.success    = 1'b1;
      result.leaf_found = leaf[SEL_W-1:0];
      return result;
   endfunction

   task automatic report_mismatch(string what, int unsigned seen, int unsigned wanted);
      $display("MISMATCH at cycle %0d: %s is %0d, expected %0d", cycle_count, what, seen,
               wanted);
      mismatch_count++;
   endtask

   // Offers one request word after a gap of idle cycles and waits for the core to take
   // it. The model is stepped at the very edge the word is accepted, so the order of
   // expectations is the order of acceptance. The valid line is only lowered when a
   // gap follows, so it never falls and rises within the same time step.
   task automatic send_word(logic kind, logic [SEL_W-1:0] leaf_select,
                            logic [BIAS_W-1:0] bias_bits, int gap, bit typed,
                            tree_outcome_type typed_outcome);
      tree_outcome_type predicted;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {{(REQ_DATA_W - SEL_W - BIAS_W){1'b0}}, bias_bits, leaf_select};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = tree_outcome(kind, leaf_select, bias_bits);
      outcomes_due.push_back(typed ? typed_outcome : predicted);
   endtask

   // Receiver: after each word it takes, it draws a number of cycles to hold
   // rsp_tready low. A pending long hold-off overrides the draw and lets the core
   // fill up while the sender keeps offering words.
   always @(negedge clock) begin
      if (long_hold_pending) begin
         stall_left        = LONG_HOLD;
         long_hold_pending = 1'b0;
      end
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Result checking against the oldest expectation, at the rising edge.
   always @(posedge clock) begin
      cycle_count++;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (outcomes_due.size() == 0) begin
            report_mismatch("unexpected result word, success", 32'(rsp_tuser), 0);
         end else begin
            oldest_due = outcomes_due.pop_front();
            if (rsp_tuser !== oldest_due.success)
               report_mismatch("success", 32'(rsp_tuser), 32'(oldest_due.success));
            if (rsp_tdata !== {{(RSP_DATA_W - SEL_W){1'b0}}, oldest_due.leaf_found})
               report_mismatch("rsp_tdata", 32'(rsp_tdata), 32'(oldest_due.leaf_found));
         end
         stall_left = quiet ? 0 : $urandom_range(0, 5);
      end
   end

   // Watchdog for a core that hangs or stops answering.
   always @(posedge clock) begin
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      int set_percent;
      logic kind;
      logic [SEL_W-1:0] leaf_select;
      logic [BIAS_W-1:0] bias_bits;
      tree_outcome_type typed_outcome;

      // Directed table: empty tree after reset, a repeated set, both ends of the leaf
      // range, takes that follow the bias and takes that must turn away from it.
      directed_rows = '{
         '{REQ_TAKE, 6'd0,  6'd0,  1'b1, 1'b0, 6'd0},   // empty tree, left bias
         '{REQ_TAKE, 6'd0,  6'd63, 1'b1, 1'b0, 6'd0},   // empty tree, right bias
         '{REQ_SET,  6'd0,  6'd0,  1'b1, 1'b1, 6'd0},
         '{REQ_SET,  6'd0,  6'd63, 1'b1, 1'b0, 6'd0},   // leaf already set
         '{REQ_SET,  6'd63, 6'd0,  1'b1, 1'b1, 6'd0},
         '{REQ_TAKE, 6'd17, 6'd0,  1'b1, 1'b1, 6'd0},   // leaf_select is ignored
         '{REQ_TAKE, 6'd5,  6'd63, 1'b1, 1'b1, 6'd63},
         '{REQ_TAKE, 6'd0,  6'd0,  1'b1, 1'b0, 6'd0},   // drained again
         '{REQ_SET,  6'd63, 6'd63, 1'b1, 1'b1, 6'd0},
         '{REQ_TAKE, 6'd0,  6'd0,  1'b1, 1'b1, 6'd63},  // left empty, goes right
         '{REQ_SET,  6'd0,  6'd0,  1'b1, 1'b1, 6'd0},
         '{REQ_TAKE, 6'd0,  6'd63, 1'b1, 1'b1, 6'd0},   // right empty, goes left
         '{REQ_SET,  6'd42, 6'd21, 1'b0, 1'b0, 6'd0},
         '{REQ_SET,  6'd21, 6'd42, 1'b0, 1'b0, 6'd0},
         '{REQ_SET,  6'd32, 6'd0,  1'b1, 1'b1, 6'd0},
         '{REQ_SET,  6'd31, 6'd0,  1'b1, 1'b1, 6'd0},
         '{REQ_TAKE, 6'd0,  6'd1,  1'b0, 1'b0, 6'd0},
         '{REQ_TAKE, 6'd0,  6'd62, 1'b0, 1'b0, 6'd0},
         '{REQ_TAKE, 6'd0,  6'd21, 1'b0, 1'b0, 6'd0},
         '{REQ_TAKE, 6'd0,  6'd42, 1'b0, 1'b0, 6'd0},
         '{REQ_SET,  6'd1,  6'd0,  1'b0, 1'b0, 6'd0},
         '{REQ_TAKE, 6'd0,  6'd0,  1'b0, 1'b0, 6'd0},
         '{REQ_TAKE, 6'd0,  6'd0,  1'b0, 1'b0, 6'd0}
      };

      // Reset is held from the start and released on a falling edge. The core then
      // sweeps its memory and keeps req_tready low, which the sender simply waits out.
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         typed_outcome.success    = directed_rows[i].success;
         typed_outcome.leaf_found = directed_rows[i].leaf_found;
         send_word(directed_rows[i].kind, directed_rows[i].leaf_select,
                   directed_rows[i].bias_bits, $urandom_range(0, 5), directed_rows[i].typed,
                   typed_outcome);
      end

      // Random run. Every 150 words the mix of sets and takes moves between filling,
      // balanced, draining and a milder fill, so the tree keeps passing through full and empty.
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         case ((n / 150) % 4)
            0: set_percent = 80;
            1: set_percent = 50;
            2: set_percent = 20;
            default: set_percent = 60;
         endcase
         quiet = (n >= 900 && n < 1050);
         // A long hold-off on the result side while words keep coming in, and later a
         // pause on the request side until the core has answered everything.
         if (n == 300)
            long_hold_pending = 1'b1;
         if (n == 700) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            while (outcomes_due.size() != 0) @(posedge clock);
         end
         kind        = ($urandom_range(0, 99) < set_percent) ? REQ_SET : REQ_TAKE;
         leaf_select = SEL_W'($urandom_range(0, LEAF_COUNT - 1));
         case ($urandom_range(0, 7))
            0: bias_bits = '0;
            1: bias_bits = '1;
            default: bias_bits = BIAS_W'($urandom_range(0, 63));
         endcase
         send_word(kind, leaf_select, bias_bits, quiet ? 0 : $urandom_range(0, 5), 1'b0,
                   '0);
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      // Drain, then keep running to catch any stray word.
      while (outcomes_due.size() != 0) @(posedge clock);
      repeat (4 * TREE_LEVELS) @(posedge clock);
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
